// ===== sv/arop_pkg.sv =====
// ----------------------------------------------------------------------------
// arop_pkg
// Item types, error codes and character codes for the register operand parser.
// ----------------------------------------------------------------------------
package arop_pkg;

  // one character of the instruction line
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
    logic [2:0] operand_pos;
  } char_item_t;

  // decoded register operand
  typedef struct packed {
    logic [4:0] reg_number;
    logic [1:0] error_code;
  } reg_item_t;

  // error codes
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_NO_DOLLAR  = 2'd1;
  localparam logic [1:0] ERR_BAD_NAME   = 2'd2;
  localparam logic [1:0] ERR_RANGE      = 2'd3;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_K      = 8'h6b;
  localparam logic [7:0] CH_O      = 8'h6f;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_Z      = 8'h7a;

  // register numbers of the fixed-name registers
  localparam logic [5:0] REG_AT   = 6'd1;
  localparam logic [5:0] REG_V0   = 6'd2;
  localparam logic [5:0] REG_A0   = 6'd4;
  localparam logic [5:0] REG_T0   = 6'd8;
  localparam logic [5:0] REG_S0   = 6'd16;
  localparam logic [5:0] REG_K0   = 6'd26;
  localparam logic [5:0] REG_GP   = 6'd28;
  localparam logic [5:0] REG_SP   = 6'd29;
  localparam logic [5:0] REG_S8   = 6'd30;
  localparam logic [5:0] REG_RA   = 6'd31;
  localparam logic [5:0] REG_NONE = 6'd32;

  localparam logic [5:0] NUM_SAT  = 6'd32;
  localparam logic [2:0] CNT_MAX  = 3'd7;
  localparam logic [2:0] ZERO_LEN = 3'd4;

endpackage

// ===== sv/assembly_register_operand_parser_unit.sv =====
// ----------------------------------------------------------------------------
// assembly_register_operand_parser_unit
// Decodes one comma-separated register operand of an assembly line, streamed
// one character per item, into a register number and an error code.
// ----------------------------------------------------------------------------
// The unit takes one character item every cycle while chr_stall is low. Each
// item is captured in an input register and processed from there against the
// line state; the item marked line_end yields one result, which is written to
// the result register when that item is processed, and the line state then
// returns to its reset values. Only a line-end item waits on a stalled result
// register; other characters keep flowing, so the sustained rate is one
// character per cycle. Error codes: 0 ok, 1 missing dollar sign or empty
// operand, 2 unrecognized name, 3 number above 31; reg_number is 0 on error.
module assembly_register_operand_parser_unit import arop_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       chr_valid,
  output logic       chr_stall,
  input  char_item_t chr,
  output logic       res_valid,
  input  logic       res_stall,
  output reg_item_t  res
);

  // input register
  logic       in_full;
  char_item_t in_q;

  // line state
  logic       past_mnemonic, past_mnemonic_next;
  logic [2:0] comma_count, comma_count_next;
  logic       collected_any, collected_any_next;
  logic       starts_with_dollar, starts_with_dollar_next;
  logic [2:0] name_length, name_length_next;
  logic [7:0] first_letter, first_letter_next;
  logic [7:0] second_letter, second_letter_next;
  logic       zero_match, zero_match_next;
  logic       all_digits, all_digits_next;
  logic [5:0] number_value, number_value_next;

  logic       out_free;
  logic       fire;
  logic       ch_digit, ch_alpha, ch_dollar, collect_en;
  logic [8:0] num_sum;
  logic [7:0] zero_char;
  logic [5:0] sym_reg;
  reg_item_t  res_next;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_0) && (ch <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ((ch >= CH_A) && (ch <= CH_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
  endfunction

  // symbolic name lookup on the first two letters, REG_NONE when unknown
  function automatic logic [5:0] decode_symbol(input logic [7:0] c0,
                                               input logic [7:0] c1,
                                               input logic       zm,
                                               input logic [2:0] len);
    logic       dig;
    logic [3:0] d;
    logic [5:0] r;
    dig = is_digit(c1);
    d   = dig ? 4'(c1 - CH_0) : 4'd0;
    r   = REG_NONE;
    case (c0)
      CH_A: begin
        if (dig && d <= 4'd3) r = REG_A0 + 6'(d);
        else if (c1 == CH_T) r = REG_AT;
      end
      CH_G: begin
        if (c1 == CH_P) r = REG_GP;
      end
      CH_K: begin
        if (dig && d <= 4'd1) r = REG_K0 + 6'(d);
      end
      CH_R: begin
        if (c1 == CH_A) r = REG_RA;
      end
      CH_S: begin
        if (dig && d <= 4'd7) r = REG_S0 + 6'(d);
        else if (dig && d == 4'd8) r = REG_S8;
        else if (c1 == CH_P) r = REG_SP;
      end
      CH_T: begin
        if (dig && d <= 4'd7) r = REG_T0 + 6'(d);
        else if (dig) r = REG_S0 + 6'(d);
      end
      CH_V: begin
        if (dig && d <= 4'd1) r = REG_V0 + 6'(d);
      end
      CH_Z: begin
        if (zm && len == ZERO_LEN) r = 6'd0;
      end
      default: r = REG_NONE;
    endcase
    return r;
  endfunction

  // handshake: only a line-end item needs room in the result register
  assign out_free  = !res_valid || !res_stall;
  assign fire      = in_full && (!in_q.line_end || out_free);
  assign chr_stall = in_full && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (chr_valid && !chr_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chr_valid && !chr_stall) begin
      in_q <= chr;
    end
  end

  // character classes
  assign ch_digit  = is_digit(in_q.char_code);
  assign ch_alpha  = is_alpha(in_q.char_code);
  assign ch_dollar = (in_q.char_code == CH_DOLLAR);

  // letter of "zero" expected at the current name position
  always_comb begin
    case (name_length[1:0])
      2'd0:    zero_char = CH_Z;
      2'd1:    zero_char = CH_E;
      2'd2:    zero_char = CH_R;
      default: zero_char = CH_O;
    endcase
  end

  assign num_sum = 9'(number_value) * 9'd10 + 9'(in_q.char_code - CH_0);

  // line state update for the item in the input register
  always_comb begin
    past_mnemonic_next      = past_mnemonic || (in_q.char_code == CH_SPACE);
    comma_count_next        = comma_count;
    collected_any_next      = collected_any;
    starts_with_dollar_next = starts_with_dollar;
    name_length_next        = name_length;
    first_letter_next       = first_letter;
    second_letter_next      = second_letter;
    zero_match_next         = zero_match;
    all_digits_next         = all_digits;
    number_value_next       = number_value;

    if (past_mnemonic && in_q.char_code == CH_COMMA && comma_count < CNT_MAX) begin
      comma_count_next = comma_count + 3'd1;
    end

    collect_en = past_mnemonic && (in_q.operand_pos == comma_count_next) &&
                 (ch_alpha || ch_digit || ch_dollar);

    if (collect_en) begin
      if (!collected_any) begin
        collected_any_next      = 1'b1;
        starts_with_dollar_next = ch_dollar;
      end
      if (!ch_dollar) begin
        if (name_length == 3'd0) first_letter_next = in_q.char_code;
        else if (name_length == 3'd1) second_letter_next = in_q.char_code;
        if (name_length >= ZERO_LEN || zero_char != in_q.char_code) begin
          zero_match_next = 1'b0;
        end
        if (ch_digit) begin
          if (number_value < NUM_SAT) begin
            number_value_next = (num_sum > 9'(NUM_SAT)) ? NUM_SAT : num_sum[5:0];
          end
        end else begin
          all_digits_next = 1'b0;
        end
        if (name_length < CNT_MAX) name_length_next = name_length + 3'd1;
      end
    end
  end

  // operand decode at line end
  assign sym_reg = decode_symbol(first_letter_next, second_letter_next,
                                 zero_match_next, name_length_next);

  always_comb begin
    res_next.reg_number = 5'd0;
    res_next.error_code = ERR_OK;
    if (!collected_any_next || !starts_with_dollar_next) begin
      res_next.error_code = ERR_NO_DOLLAR;
    end else if (name_length_next == 3'd0) begin
      res_next.error_code = ERR_BAD_NAME;
    end else if (is_alpha(first_letter_next)) begin
      if (sym_reg == REG_NONE) res_next.error_code = ERR_BAD_NAME;
      else res_next.reg_number = sym_reg[4:0];
    end else if (!all_digits_next) begin
      res_next.error_code = ERR_BAD_NAME;
    end else if (number_value_next > 6'd31) begin
      res_next.error_code = ERR_RANGE;
    end else begin
      res_next.reg_number = number_value_next[4:0];
    end
  end

  // line state registers, cleared after each line
  always_ff @(posedge clk) begin
    if (rst || (fire && in_q.line_end)) begin
      past_mnemonic      <= 1'b0;
      comma_count        <= 3'd0;
      collected_any      <= 1'b0;
      starts_with_dollar <= 1'b0;
      name_length        <= 3'd0;
      first_letter       <= 8'd0;
      second_letter      <= 8'd0;
      zero_match         <= 1'b1;
      all_digits         <= 1'b1;
      number_value       <= 6'd0;
    end else if (fire) begin
      past_mnemonic      <= past_mnemonic_next;
      comma_count        <= comma_count_next;
      collected_any      <= collected_any_next;
      starts_with_dollar <= starts_with_dollar_next;
      name_length        <= name_length_next;
      first_letter       <= first_letter_next;
      second_letter      <= second_letter_next;
      zero_match         <= zero_match_next;
      all_digits         <= all_digits_next;
      number_value       <= number_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && in_q.line_end) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_q.line_end) begin
      res <= res_next;
    end
  end

endmodule

// ===== sv/arop_checker.sv =====
// ----------------------------------------------------------------------------
// arop_checker
// Port-level checks for the register operand parser, bound to the top level.
// ----------------------------------------------------------------------------
module arop_checker import arop_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       chr_valid,
  input logic       chr_stall,
  input char_item_t chr,
  input logic       res_valid,
  input logic       res_stall,
  input reg_item_t  res
);

  // line-end items accepted whose result is not yet taken
  logic [2:0] pending;
  logic       line_in;
  logic       res_out;

  assign line_in = chr_valid && !chr_stall && chr.line_end;
  assign res_out = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else if (line_in && !res_out) begin
      pending <= pending + 3'd1;
    end else if (!line_in && res_out && pending != 3'd0) begin
      pending <= pending - 3'd1;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // errors report register zero
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error_code != ERR_OK |-> res.reg_number == 5'd0)
    else $error("nonzero register with error");

  // every result answers an accepted line end
  assert property (@(posedge clk) disable iff (rst)
    res_out |-> pending != 3'd0)
    else $error("result without line end");

  // at most two lines in flight: input register and result register
  assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("too many lines in flight");

endmodule

bind assembly_register_operand_parser_unit arop_checker u_arop_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the register operand parser against an in-bench line parser model.
// A driver streams character items from a queue of prepared lines, a monitor
// compares each decoded register item with the oldest prediction, and both
// sides idle and stall at random in the first two of three phases.
// ----------------------------------------------------------------------------
module testbench;
  import arop_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 1700;
  localparam int RANDOM_CHARS = 2000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    char_item_t item;
    bit         pause;
  } pending_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       chr_valid = 1'b0;
  logic       chr_stall;
  char_item_t chr = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  reg_item_t  res;

  // line parser model state
  logic       seen_space;
  logic [2:0] commas;
  logic       got_any;
  logic       lead_dollar;
  logic [2:0] name_len;
  logic [7:0] letter0;
  logic [7:0] letter1;
  logic       zero_ok;
  logic       digits_only;
  logic [5:0] num_val;

  logic [7:0] zero_word [4] = '{CH_Z, CH_E, CH_R, CH_O};

  string reg_names [33] = '{"zero", "at", "v0", "v1", "a0", "a1", "a2", "a3",
    "t0", "t1", "t2", "t3", "t4", "t5", "t6", "t7", "t8", "t9",
    "s0", "s1", "s2", "s3", "s4", "s5", "s6", "s7", "s8",
    "k0", "k1", "gp", "sp", "fp", "ra"};

  pending_char_t line_chars [$];
  reg_item_t     expected_regs [$];
  logic [7:0]    line_buf [$];

  int chars_accepted = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  assembly_register_operand_parser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #10 clk = ~clk;

  function automatic bit is_digit_ch(logic [7:0] ch);
    return ch >= CH_0 && ch <= CH_9;
  endfunction

  function automatic bit is_alpha_ch(logic [7:0] ch);
    return (ch >= CH_A && ch <= CH_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z);
  endfunction

  // idle percentage of each side by phase
  function automatic int idle_pct(bit receiver);
    if (chars_accepted < 700) return receiver ? 53 : 24;
    if (chars_accepted < 1400) return receiver ? 24 : 53;
    return 0;
  endfunction

  task automatic clear_line();
    seen_space  = 1'b0;
    commas      = '0;
    got_any     = 1'b0;
    lead_dollar = 1'b0;
    name_len    = '0;
    letter0     = '0;
    letter1     = '0;
    zero_ok     = 1'b1;
    digits_only = 1'b1;
    num_val     = '0;
  endtask

  // symbolic name from its first two letters, REG_NONE when unknown
  function automatic logic [5:0] decode_name();
    logic       dig;
    logic [3:0] d;
    dig = is_digit_ch(letter1);
    d = dig ? 4'(letter1 - CH_0) : 4'd0;
    case (letter0)
      CH_A: begin
        if (dig && d <= 3) return REG_A0 + 6'(d);
        if (letter1 == CH_T) return REG_AT;
      end
      CH_G: begin
        if (letter1 == CH_P) return REG_GP;
      end
      CH_K: begin
        if (dig && d <= 1) return REG_K0 + 6'(d);
      end
      CH_R: begin
        if (letter1 == CH_A) return REG_RA;
      end
      CH_S: begin
        if (dig && d <= 7) return REG_S0 + 6'(d);
        if (dig && d == 8) return REG_S8;
        if (letter1 == CH_P) return REG_SP;
      end
      CH_T: begin
        if (dig && d <= 7) return REG_T0 + 6'(d);
        if (dig && d <= 9) return REG_S0 + 6'(d);
      end
      CH_V: begin
        if (dig && d <= 1) return REG_V0 + 6'(d);
      end
      CH_Z: begin
        if (zero_ok && name_len == ZERO_LEN) return 6'd0;
      end
      default: ;
    endcase
    return REG_NONE;
  endfunction

  // advance the line state by one character, predict a result at line end
  task automatic parse_char(char_item_t c);
    logic [7:0] ch;
    int         acc;
    logic [5:0] code;
    reg_item_t  r;
    ch = c.char_code;
    if (seen_space && ch == CH_COMMA && commas < CNT_MAX) commas++;
    if (seen_space && c.operand_pos == commas &&
        (is_alpha_ch(ch) || is_digit_ch(ch) || ch == CH_DOLLAR)) begin
      if (!got_any) begin
        got_any = 1'b1;
        lead_dollar = (ch == CH_DOLLAR);
      end
      if (ch != CH_DOLLAR) begin
        if (name_len == 0) letter0 = ch;
        else if (name_len == 1) letter1 = ch;
        if (name_len < ZERO_LEN) begin
          if (zero_word[name_len[1:0]] != ch) zero_ok = 1'b0;
        end else begin
          zero_ok = 1'b0;
        end
        if (is_digit_ch(ch)) begin
          if (num_val < NUM_SAT) begin
            acc = num_val * 10 + ch - CH_0;
            num_val = (acc > NUM_SAT) ? NUM_SAT : 6'(acc);
          end
        end else begin
          digits_only = 1'b0;
        end
        if (name_len < CNT_MAX) name_len++;
      end
    end
    if (ch == CH_SPACE) seen_space = 1'b1;
    if (c.line_end) begin
      r.reg_number = '0;
      r.error_code = ERR_OK;
      if (!got_any || !lead_dollar) begin
        r.error_code = ERR_NO_DOLLAR;
      end else if (name_len == 0) begin
        r.error_code = ERR_BAD_NAME;
      end else if (is_alpha_ch(letter0)) begin
        code = decode_name();
        if (code == REG_NONE) r.error_code = ERR_BAD_NAME;
        else r.reg_number = code[4:0];
      end else if (!digits_only) begin
        r.error_code = ERR_BAD_NAME;
      end else if (num_val >= NUM_SAT) begin
        r.error_code = ERR_RANGE;
      end else begin
        r.reg_number = num_val[4:0];
      end
      expected_regs = {expected_regs, r};
      clear_line();
    end
  endtask

  task automatic check_register(reg_item_t got);
    reg_item_t want;
    if (expected_regs.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected register item: reg %0d err %0d",
                 got.reg_number, got.error_code);
    end else begin
      want = expected_regs.pop_front();
      if (got.reg_number !== want.reg_number || got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch%s%s: expected reg %0d err %0d, got reg %0d err %0d",
                   (got.reg_number !== want.reg_number) ? " reg_number" : "",
                   (got.error_code !== want.error_code) ? " error_code" : "",
                   want.reg_number, want.error_code, got.reg_number, got.error_code);
      end
    end
  endtask

  // append one byte to the line buffer
  task automatic add_byte(logic [7:0] b);
    line_buf = {line_buf, b};
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // turn the line buffer into character items
  task automatic queue_line(logic [2:0] pos, bit pause, bit wobble);
    pending_char_t p;
    foreach (line_buf[i]) begin
      p.item.char_code   = line_buf[i];
      p.item.line_end    = (i == line_buf.size() - 1);
      p.item.operand_pos = (wobble && $urandom_range(3) == 0) ? 3'($urandom_range(7)) : pos;
      p.pause            = pause && (i == 0);
      line_chars = {line_chars, p};
    end
    line_buf.delete();
  endtask

  task automatic add_line(string s, logic [2:0] pos);
    put_text(s);
    queue_line(pos, 1'b0, 1'b0);
  endtask

  function automatic string make_operand();
    int    kind;
    int    val;
    string nm;
    string s;
    kind = $urandom_range(99);
    nm = reg_names[$urandom_range(32)];
    if (kind < 55) return {"$", nm};
    if (kind < 75) begin
      val = ($urandom_range(9) == 0) ? $urandom_range(99999) : $urandom_range(40);
      s = ($urandom_range(4) == 0) ? "$0" : "$";
      return $sformatf("%s%0d", s, val);
    end
    if (kind < 79) return nm;
    if (kind < 82) return {"$$", nm};
    if (kind < 84) return "$";
    if (kind < 87) return "";
    if (kind < 90) return {"$", nm.toupper()};
    if (kind < 93) return $sformatf("$%0d%s", $urandom_range(9), nm);
    if (kind < 96) return {"$", nm, nm};
    s = "$";
    repeat ($urandom_range(1, 5)) s = $sformatf("%s%c", s, $urandom_range(CH_A, CH_Z));
    return s;
  endfunction

  // stimulus, reset and end of run
  initial begin
    int    base;
    int    ops;
    int    n;
    bit    pause;
    bit    mid_pause_done;
    string noise_pool;
    noise_pool = " ,$0123456789atsz";
    mid_pause_done = 1'b0;

    // directed lines
    add_line("add $t0,$s1,$zero", 0);
    add_line("add $t0,$s1,$zero", 2);
    add_line("jr $ra", 0);
    add_line("lw $at,$gp", 1);
    add_line("or $sp,$s8", 0);
    add_line("or $sp,$s8", 1);
    add_line("x $k1,$v1,$a3", 0);
    add_line("x $k1,$v1,$a3", 1);
    add_line("x $k1,$v1,$a3", 2);
    add_line("x $t9", 0);
    add_line("x $31,$007,$32", 0);
    add_line("x $31,$007,$32", 1);
    add_line("x $31,$007,$32", 2);
    add_line("x $123456", 0);
    add_line("x $,$$", 1);
    add_line("x ,", 0);
    add_line("x t0", 0);
    add_line("x $t", 0);
    add_line("x $T0", 0);
    add_line("x $3a", 0);
    add_line("x $zeros,$zer", 0);
    add_line("x $zeros,$zer", 1);
    add_line("x $$s7", 0);
    add_line("nop", 0);
    add_line("x 1,2,3,4,5,6,7,$8,$9", 7);
    add_line("x $fp", 0);
    add_line("x $t1", 7);
    // bytes outside ascii are skipped inside a name
    add_byte(8'h00);
    put_text("x $t");
    add_byte(8'hff);
    add_byte(8'h80);
    put_text("1");
    queue_line(3'd0, 1'b0, 1'b0);
    put_text("x $t1,$t2");
    queue_line(3'd1, 1'b0, 1'b1);

    // random lines, mostly well formed
    base = line_chars.size();
    while (line_chars.size() < base + RANDOM_CHARS) begin
      pause = (line_chars.size() == base);
      if (!mid_pause_done && line_chars.size() >= base + RANDOM_CHARS / 2) begin
        pause = 1'b1;
        mid_pause_done = 1'b1;
      end
      if ($urandom_range(99) < 8) begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          if ($urandom_range(1))
            add_byte(noise_pool[$urandom_range(noise_pool.len() - 1)]);
          else
            add_byte(8'($urandom_range(255)));
        end
        queue_line(3'($urandom_range(7)), pause, 1'b1);
      end else begin
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(CH_A, CH_Z)));
        add_byte(CH_SPACE);
        ops = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 11);
        for (int i = 0; i < ops; i++) begin
          if (i > 0) put_text(($urandom_range(3) == 0) ? ", " : ",");
          put_text(make_operand());
        end
        if ($urandom_range(9) == 0)
          line_buf.insert($urandom_range(line_buf.size() - 1), 8'($urandom_range(255)));
        if (ops <= 8 && $urandom_range(9) < 8)
          queue_line(3'($urandom_range(ops - 1)), pause, 1'b0);
        else
          queue_line(3'($urandom_range(7)), pause, 1'b0);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (line_chars.size() == 0 && !chr_valid);
    wait (expected_regs.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // driver: offers queued character items, feeds the model on acceptance
  always @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
      clear_line();
    end else begin
      if (chr_valid && !chr_stall) begin
        parse_char(chr);
        chars_accepted <= chars_accepted + 1;
      end
      if (!chr_valid || !chr_stall) begin
        if (line_chars.size() > 0 && !(line_chars[0].pause && expected_regs.size() > 0) &&
            (hold_left > 0 || $urandom_range(99) >= idle_pct(1'b0))) begin
          chr <= line_chars[0].item;
          void'(line_chars.pop_front());
          chr_valid <= 1'b1;
        end else begin
          chr_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result items, drives random stall and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) check_register(res);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else if (!hold_done && chars_accepted >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < idle_pct(1'b1));
      end
    end
  end

  // cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (chr_valid && !chr_stall) || (res_valid && !res_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/arop_pkg.sv
sv/assembly_register_operand_parser_unit.sv
sv/arop_checker.sv
verif/testbench.sv
